[rtl/nist_pkg.sv]
// ----------------------------------------------------------------------------
// nist_pkg
// Shared types and constants for the node id slot table.
// ----------------------------------------------------------------------------
package nist_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int OPCODE_W  = 2;
    localparam int IDENT_W   = 8;
    localparam int HANDLE_W  = 8;
    localparam int SLOT_W    = 4;

    localparam logic [OPCODE_W-1:0] OP_REGISTER   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FIND       = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_READ       = 2'd3;

    typedef struct packed {
        logic                fire;
        logic [OPCODE_W-1:0] opcode;
        logic [IDENT_W-1:0]  node_ident;
        logic [HANDLE_W-1:0] slot_handle;
    } req_t;

    // Carried from each cell to the next one up the row.
    typedef struct packed {
        logic               claimed;
        logic               ok;
        logic [SLOT_W-1:0]  slot;
        logic [IDENT_W-1:0] ident;
    } chain_t;

endpackage

[rtl/nist_if.sv]
// ----------------------------------------------------------------------------
// nist_req_if / nist_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface nist_req_if;
    logic                          valid;
    logic                          ready;
    logic [nist_pkg::OPCODE_W-1:0] opcode;
    logic [nist_pkg::IDENT_W-1:0]  node_ident;
    logic [nist_pkg::HANDLE_W-1:0] slot_handle;

    modport source (output valid, opcode, node_ident, slot_handle, input ready);
    modport sink   (input valid, opcode, node_ident, slot_handle, output ready);
endinterface

interface nist_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [nist_pkg::SLOT_W-1:0]  slot_out;
    logic [nist_pkg::IDENT_W-1:0] ident_out;

    modport source (output valid, ok, slot_out, ident_out, input ready);
    modport sink   (input valid, ok, slot_out, ident_out, output ready);
endinterface

[rtl/nist_cell.sv]
// ----------------------------------------------------------------------------
// nist_cell
// One slot of the table: holds an id and its used flag, and updates the
// response handed along the row of cells.
// ----------------------------------------------------------------------------
module nist_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [nist_pkg::SLOT_W-1:0] slot_index,
    input  nist_pkg::req_t              req,
    input  nist_pkg::chain_t            chain_in,
    output nist_pkg::chain_t            chain_out,
    output logic                        take
);

    logic                         used_reg;
    logic                         used_next;
    logic [nist_pkg::IDENT_W-1:0] ident_reg;
    logic [nist_pkg::IDENT_W-1:0] ident_next;
    logic                         handle_hit;
    logic                         ident_hit;

    assign handle_hit = req.slot_handle ==
                        {{(nist_pkg::HANDLE_W-nist_pkg::SLOT_W){1'b0}}, slot_index};
    assign ident_hit  = used_reg && (ident_reg == req.node_ident);
    assign take       = (req.opcode == nist_pkg::OP_REGISTER) && !chain_in.claimed
                        && !used_reg;

    always_comb
    begin
        chain_out         = chain_in;
        chain_out.claimed = chain_in.claimed || !used_reg;
        case (req.opcode)
            nist_pkg::OP_REGISTER:
            begin
                if (take)
                begin
                    chain_out.ok   = 1'b1;
                    chain_out.slot = slot_index;
                end
            end
            nist_pkg::OP_FIND:
            begin
                // Later cells overwrite, so the highest matching slot wins.
                if (ident_hit)
                begin
                    chain_out.ok   = 1'b1;
                    chain_out.slot = slot_index;
                end
            end
            nist_pkg::OP_UNREGISTER:
            begin
                if (handle_hit)
                begin
                    chain_out.ok   = 1'b1;
                    chain_out.slot = slot_index;
                end
            end
            default:
            begin
                if (handle_hit && used_reg)
                begin
                    chain_out.ok    = 1'b1;
                    chain_out.slot  = slot_index;
                    chain_out.ident = ident_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        used_next  = used_reg;
        ident_next = ident_reg;
        if (req.fire && take)
        begin
            used_next  = 1'b1;
            ident_next = req.node_ident;
        end
        else if (req.fire && (req.opcode == nist_pkg::OP_UNREGISTER) && handle_hit)
        begin
            used_next  = 1'b0;
            ident_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            ident_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            ident_reg <= ident_next;
        end
    end

    // A free slot always holds a cleared id.
    a_free_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !used_reg |-> ident_reg == '0)
        else $error("free slot holds a nonzero id");

endmodule

[rtl/node_id_slot_table.sv]
// ----------------------------------------------------------------------------
// node_id_slot_table
// Table of node ids in a row of slot cells; register, find, unregister and
// read requests each give one response beat.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  req      in   opcode, node_ident, slot_handle
//  rsp      out  ok, slot_out, ident_out
//
//  A request beat is answered in the cycle after it is taken, so one request
//  per cycle is sustained while rsp is ready; the ripple through the row of
//  cells sets the cycle's logic depth. The response sits in an output register,
//  and a new request is taken whenever that register is empty or being drained.
//  Reset clears every slot to free with a zero id. A stalled rsp holds the
//  response and stalls req until it is taken.
module node_id_slot_table (
    input  logic       clk,
    input  logic       rst_n,
    nist_req_if.sink   req,
    nist_rsp_if.source rsp
);

    nist_pkg::req_t   cell_req;
    nist_pkg::chain_t chain [nist_pkg::NUM_SLOTS+1];
    logic [nist_pkg::NUM_SLOTS-1:0] take;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         ok_reg;
    logic [nist_pkg::SLOT_W-1:0]  slot_reg;
    logic [nist_pkg::IDENT_W-1:0] ident_reg;
    logic                         fire;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    assign cell_req.fire        = fire;
    assign cell_req.opcode      = req.opcode;
    assign cell_req.node_ident  = req.node_ident;
    assign cell_req.slot_handle = req.slot_handle;

    assign chain[0] = '0;

    for (genvar k = 0; k < nist_pkg::NUM_SLOTS; k++)
    begin : g_cell
        nist_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot_index (nist_pkg::SLOT_W'(k)),
            .req        (cell_req),
            .chain_in   (chain[k]),
            .chain_out  (chain[k+1]),
            .take       (take[k])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg    <= chain[nist_pkg::NUM_SLOTS].ok;
            slot_reg  <= chain[nist_pkg::NUM_SLOTS].slot;
            ident_reg <= chain[nist_pkg::NUM_SLOTS].ident;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = ok_reg;
    assign rsp.slot_out  = slot_reg;
    assign rsp.ident_out = ident_reg;

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(take))
        else $error("more than one slot claimed by a register");

    a_answer_next: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp.valid)
        else $error("accepted request not answered in the next cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ok |-> rsp.slot_out == '0 && rsp.ident_out == '0)
        else $error("failed response carries nonzero fields");

endmodule

[verif/node_id_slot_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_id_slot_table_tb
// Drives register, find, unregister and read requests into the slot table,
// predicts each response from a local copy of the table and checks every
// response beat field by field, part of the run under random idling on both channels.
// ----------------------------------------------------------------------------
module node_id_slot_table_tb;

    typedef struct packed {
        logic                         ok;
        logic [nist_pkg::SLOT_W-1:0]  slot;
        logic [nist_pkg::IDENT_W-1:0] ident;
    } table_reply_t;

    logic clk;
    logic rst_n;

    nist_req_if req_ch ();
    nist_rsp_if rsp_ch ();

    node_id_slot_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Local copy of the table, updated as each request beat is taken.
    logic [nist_pkg::IDENT_W-1:0] table_ident [nist_pkg::NUM_SLOTS];
    logic                         table_used  [nist_pkg::NUM_SLOTS];

    table_reply_t pending_replies [$];
    table_reply_t want_reply;
    int           error_count;

    bit source_idling;
    bit sink_idling;
    int long_hold_cycles;

    logic [nist_pkg::IDENT_W-1:0] ident_pool [6] =
        '{8'h00, 8'h01, 8'h55, 8'hAA, 8'h80, 8'hFF};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic table_reply_t predict_reply(
        logic [nist_pkg::OPCODE_W-1:0] op,
        logic [nist_pkg::IDENT_W-1:0]  ident,
        logic [nist_pkg::HANDLE_W-1:0] handle);
        table_reply_t                             reply;
        bit                                       placed;
        logic [$clog2(nist_pkg::NUM_SLOTS)-1:0]   slot_idx;
        reply    = '0;
        placed   = 1'b0;
        slot_idx = handle[$clog2(nist_pkg::NUM_SLOTS)-1:0];
        case (op)
            nist_pkg::OP_REGISTER:
            begin
                for (int k = 0; k < nist_pkg::NUM_SLOTS; k++)
                begin
                    if (!placed && !table_used[k])
                    begin
                        table_used[k]  = 1'b1;
                        table_ident[k] = ident;
                        reply.ok       = 1'b1;
                        reply.slot     = nist_pkg::SLOT_W'(k);
                        placed         = 1'b1;
                    end
                end
            end
            nist_pkg::OP_FIND:
            begin
                // Later slots overwrite earlier ones, so the highest match wins.
                for (int k = 0; k < nist_pkg::NUM_SLOTS; k++)
                begin
                    if (table_used[k] && table_ident[k] == ident)
                    begin
                        reply.ok   = 1'b1;
                        reply.slot = nist_pkg::SLOT_W'(k);
                    end
                end
            end
            nist_pkg::OP_UNREGISTER:
            begin
                if (handle < nist_pkg::NUM_SLOTS)
                begin
                    table_used[slot_idx]  = 1'b0;
                    table_ident[slot_idx] = '0;
                    reply.ok              = 1'b1;
                    reply.slot            = handle[nist_pkg::SLOT_W-1:0];
                end
            end
            default:
            begin
                if (handle < nist_pkg::NUM_SLOTS && table_used[slot_idx])
                begin
                    reply.ok    = 1'b1;
                    reply.slot  = handle[nist_pkg::SLOT_W-1:0];
                    reply.ident = table_ident[slot_idx];
                end
            end
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Entered just after the previous beat was taken, or at the start.
    task automatic send_request(input logic [nist_pkg::OPCODE_W-1:0] op,
                                input logic [nist_pkg::IDENT_W-1:0]  ident,
                                input logic [nist_pkg::HANDLE_W-1:0] handle);
        int gap;
        gap = source_idling ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.node_ident  <= ident;
        req_ch.slot_handle <= handle;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_replies.push_back(predict_reply(op, ident, handle));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic test_directed();
        // Free slots hold id zero but must never match a find.
        send_request(nist_pkg::OP_FIND,       8'h00, 8'hFF);
        send_request(nist_pkg::OP_FIND,       8'hFF, 8'h00);
        send_request(nist_pkg::OP_READ,       8'hFF, 8'h00);
        send_request(nist_pkg::OP_REGISTER,   8'hFF, 8'hFF);
        send_request(nist_pkg::OP_REGISTER,   8'h00, 8'h00);
        send_request(nist_pkg::OP_REGISTER,   8'hFF, 8'h03);
        send_request(nist_pkg::OP_REGISTER,   8'h5A, 8'h80);
        // Table full.
        send_request(nist_pkg::OP_REGISTER,   8'h01, 8'h00);
        send_request(nist_pkg::OP_FIND,       8'hFF, 8'h00);
        send_request(nist_pkg::OP_FIND,       8'h00, 8'hFF);
        send_request(nist_pkg::OP_FIND,       8'hA5, 8'h00);
        send_request(nist_pkg::OP_READ,       8'h00, 8'h00);
        send_request(nist_pkg::OP_READ,       8'hFF, 8'h03);
        // Handles beyond the table are ignored.
        send_request(nist_pkg::OP_READ,       8'h00, 8'h04);
        send_request(nist_pkg::OP_READ,       8'h00, 8'hFF);
        send_request(nist_pkg::OP_UNREGISTER, 8'h00, 8'hFF);
        send_request(nist_pkg::OP_UNREGISTER, 8'hFF, 8'h04);
        send_request(nist_pkg::OP_UNREGISTER, 8'h00, 8'h02);
        send_request(nist_pkg::OP_FIND,       8'hFF, 8'h00);
        send_request(nist_pkg::OP_READ,       8'h00, 8'h02);
        // Unregister of a slot that is already free still succeeds.
        send_request(nist_pkg::OP_UNREGISTER, 8'h00, 8'h02);
        send_request(nist_pkg::OP_REGISTER,   8'hC3, 8'h00);
        send_request(nist_pkg::OP_UNREGISTER, 8'h00, 8'h00);
        send_request(nist_pkg::OP_UNREGISTER, 8'h00, 8'h01);
        send_request(nist_pkg::OP_FIND,       8'h00, 8'h00);
    endtask

    task automatic send_random_request();
        logic [nist_pkg::OPCODE_W-1:0] op;
        logic [nist_pkg::IDENT_W-1:0]  ident;
        logic [nist_pkg::HANDLE_W-1:0] handle;
        int                            roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            op = nist_pkg::OP_REGISTER;
        else if (roll < 60)
            op = nist_pkg::OP_FIND;
        else if (roll < 80)
            op = nist_pkg::OP_UNREGISTER;
        else
            op = nist_pkg::OP_READ;
        // A small pool of ids keeps finds hitting and duplicates common.
        if ($urandom_range(0, 99) < 70)
            ident = ident_pool[$urandom_range(0, 5)];
        else
            ident = nist_pkg::IDENT_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85)
            handle = nist_pkg::HANDLE_W'($urandom_range(0, nist_pkg::NUM_SLOTS - 1));
        else
            handle = nist_pkg::HANDLE_W'($urandom_range(nist_pkg::NUM_SLOTS, 255));
        send_request(op, ident, handle);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_request();
    endtask

    task automatic test_back_pressure();
        bit saved_idling;
        saved_idling  = source_idling;
        source_idling = 1'b0;
        long_hold_cycles = 60;
        repeat (30) send_random_request();
        source_idling = saved_idling;
    endtask

    // Response sink: random ready, with a long hold-off on request.
    initial
    begin : response_sink
        int stall_left;
        int run_left;
        stall_left   = 0;
        run_left     = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles != 0)
            begin
                stall_left       = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if (sink_idling)
                begin
                    stall_left = pick_gap();
                    run_left   = $urandom_range(0, 12);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("response beat with no request pending");
            else
            begin
                want_reply = pending_replies.pop_front();
                if (rsp_ch.ok !== want_reply.ok)
                    report_mismatch($sformatf("ok: expected %0d got %0d",
                                              want_reply.ok, rsp_ch.ok));
                if (rsp_ch.slot_out !== want_reply.slot)
                    report_mismatch($sformatf("slot_out: expected %0d got %0d",
                                              want_reply.slot, rsp_ch.slot_out));
                if (rsp_ch.ident_out !== want_reply.ident)
                    report_mismatch($sformatf("ident_out: expected %0h got %0h",
                                              want_reply.ident, rsp_ch.ident_out));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        error_count        = 0;
        source_idling      = 1'b0;
        sink_idling        = 1'b0;
        long_hold_cycles   = 0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = nist_pkg::OP_REGISTER;
        req_ch.node_ident  = '0;
        req_ch.slot_handle = '0;
        for (int k = 0; k < nist_pkg::NUM_SLOTS; k++)
        begin
            table_ident[k] = '0;
            table_used[k]  = 1'b0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(200);
        source_idling = 1'b1;
        sink_idling   = 1'b1;
        test_random(250);
        test_back_pressure();
        test_random(250);
        stop_sending();

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
